>>> rtl/mhf_pkg.sv
// ----------------------------------------------------------------------------
// mhf_pkg
// Shared constants, types and helpers of the masked 3x3 hole fill block.
// ----------------------------------------------------------------------------
package mhf_pkg;

  // Geometry and value width
  localparam int MAX_COLS   = 1024;
  localparam int VALUE_BITS = 16;
  localparam int RING       = 2 * MAX_COLS + 3;
  localparam int PTR_W      = $clog2(RING);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int PEND_W     = $clog2(MAX_COLS + 2);
  localparam int WORD_W     = VALUE_BITS + 1;
  localparam int SUM_W      = VALUE_BITS + 3;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int CALC_W     = PTR_W + 2;

  // Configuration registers
  localparam int NCOL_W     = 11;
  localparam int NROW_W     = 16;
  localparam int MINN_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NEIGHBORS = 2'd2;

  localparam logic [NCOL_W-1:0] NUM_COLS_RST      = 11'd1024;
  localparam logic [NROW_W-1:0] NUM_ROWS_RST      = 16'd1024;
  localparam logic [MINN_W-1:0] MIN_NEIGHBORS_RST = 4'd4;

  localparam logic [2:0] LAST_NEIGHBOR = 3'd7;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTR_RD,
    ST_CTR_WT,
    ST_NB_RD,
    ST_NB_ACC,
    ST_NB_END,
    ST_DIV,
    ST_MEAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic ctr_rd;
    logic ctr_latch;
    logic nb_rd;
    logic nb_acc;
    logic div_init;
    logic div_step;
    logic mean_load;
    logic out_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic hole;
    logic nb_last;
    logic fill_ok;
    logic div_last;
  } dp_stat_t;

  // Direction flags of one window neighbor
  typedef struct packed {
    logic r_neg;
    logic r_pos;
    logic c_neg;
    logic c_pos;
  } nb_ofs_t;

  // Map a neighbor number to its offset, row by row, center left out
  function automatic nb_ofs_t nb_offset(input logic [2:0] k);
    nb_ofs_t o;
    o = '0;
    unique case (k)
      3'd0: o = '{r_neg: 1'b1, r_pos: 1'b0, c_neg: 1'b1, c_pos: 1'b0};
      3'd1: o = '{r_neg: 1'b1, r_pos: 1'b0, c_neg: 1'b0, c_pos: 1'b0};
      3'd2: o = '{r_neg: 1'b1, r_pos: 1'b0, c_neg: 1'b0, c_pos: 1'b1};
      3'd3: o = '{r_neg: 1'b0, r_pos: 1'b0, c_neg: 1'b1, c_pos: 1'b0};
      3'd4: o = '{r_neg: 1'b0, r_pos: 1'b0, c_neg: 1'b0, c_pos: 1'b1};
      3'd5: o = '{r_neg: 1'b0, r_pos: 1'b1, c_neg: 1'b1, c_pos: 1'b0};
      3'd6: o = '{r_neg: 1'b0, r_pos: 1'b1, c_neg: 1'b0, c_pos: 1'b0};
      3'd7: o = '{r_neg: 1'b0, r_pos: 1'b1, c_neg: 1'b0, c_pos: 1'b1};
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

>>> rtl/mhf_in_if.sv
// ----------------------------------------------------------------------------
// mhf_in_if
// Input channel: one pixel item or drain tick per transaction.
// ----------------------------------------------------------------------------
interface mhf_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic                           frame_start;
  logic [mhf_pkg::VALUE_BITS-1:0] pixel_value;
  logic                           in_domain;

  modport source(output valid, cmd, frame_start, pixel_value, in_domain, input ready);
  modport sink(input valid, cmd, frame_start, pixel_value, in_domain, output ready);
endinterface

>>> rtl/mhf_out_if.sv
// ----------------------------------------------------------------------------
// mhf_out_if
// Output channel: one pixel result per transaction.
// ----------------------------------------------------------------------------
interface mhf_out_if;
  logic                           valid;
  logic                           ready;
  logic [mhf_pkg::VALUE_BITS-1:0] out_value;
  logic                           was_filled;
  logic                           frame_end;

  modport source(output valid, out_value, was_filled, frame_end, input ready);
  modport sink(input valid, out_value, was_filled, frame_end, output ready);
endinterface

>>> rtl/masked_hole_fill_3x3.sv
// Sequence: a triggering transaction reads the center; a hole then reads and
// accumulates its eight neighbors in turn over one ring read port, and a
// filled hole runs the serial divider, one quotient bit per cycle.
// One transaction is in flight at a time; an item with no result leaves the block ready.
// Reset: asynchronous, active low; ring contents stay undefined, age counter
// marks them stale, registers return to 1024 columns, 1024 rows, 4 neighbors.
// ----------------------------------------------------------------------------
// masked_hole_fill_3x3
// Top level: fills masked-in zero pixels with the mean of their 3x3 window.
// ----------------------------------------------------------------------------
module masked_hole_fill_3x3 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mhf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mhf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mhf_in_if.sink                         in_i,
  mhf_out_if.source                      out_o
);
  import mhf_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  mhf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath
  mhf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (in_i.cmd),
    .frame_start_i (in_i.frame_start),
    .pixel_value_i (in_i.pixel_value),
    .in_domain_i   (in_i.in_domain),
    .cmd           (cmd),
    .stat_o        (stat),
    .out_value_o   (out_o.out_value),
    .was_filled_o  (out_o.was_filled),
    .frame_end_o   (out_o.frame_end)
  );

`ifndef ASSERT_OFF
  // No new transaction while a result waits
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a result is pending");

  // An item that triggers nothing leaves the output idle
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !stat.emit_req) |=> !out_o.valid)
    else $error("result without a trigger");

  // Return to accepting after a result is taken
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> in_i.ready)
    else $error("block not ready after result handoff");
`endif

endmodule

>>> rtl/mhf_ram.sv
// ----------------------------------------------------------------------------
// mhf_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mhf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/mhf_ctrl.sv
// ----------------------------------------------------------------------------
// mhf_ctrl
// Sequencer: accept, center read, neighbor sweep, divide, result handoff.
// ----------------------------------------------------------------------------
module mhf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mhf_pkg::dp_stat_t  stat_i,
  output mhf_pkg::ctrl_cmd_t cmd_o
);
  import mhf_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.emit_req) state_d = ST_CTR_RD;
        end
      end
      ST_CTR_RD: begin
        cmd_o.ctr_rd = 1'b1;
        state_d      = ST_CTR_WT;
      end
      ST_CTR_WT: begin
        cmd_o.ctr_latch = 1'b1;
        state_d         = stat_i.hole ? ST_NB_RD : ST_OUT;
      end
      ST_NB_RD: begin
        cmd_o.nb_rd = 1'b1;
        state_d     = ST_NB_ACC;
      end
      ST_NB_ACC: begin
        cmd_o.nb_acc = 1'b1;
        state_d      = stat_i.nb_last ? ST_NB_END : ST_NB_RD;
      end
      ST_NB_END: begin
        if (stat_i.fill_ok) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_MEAN;
      end
      ST_MEAN: begin
        cmd_o.mean_load = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_done = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/mhf_dp.sv
// ----------------------------------------------------------------------------
// mhf_dp
// Datapath: pixel ring, positions, neighbor sum and count, serial divider.
// ----------------------------------------------------------------------------
module mhf_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mhf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mhf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           cmd_i,
  input  logic                           frame_start_i,
  input  logic [mhf_pkg::VALUE_BITS-1:0] pixel_value_i,
  input  logic                           in_domain_i,
  input  mhf_pkg::ctrl_cmd_t             cmd,
  output mhf_pkg::dp_stat_t              stat_o,
  output logic [mhf_pkg::VALUE_BITS-1:0] out_value_o,
  output logic                           was_filled_o,
  output logic                           frame_end_o
);
  import mhf_pkg::*;

  logic [NCOL_W-1:0]     ncols_q;
  logic [NROW_W-1:0]     nrows_q;
  logic [MINN_W-1:0]     minn_q;
  logic [PTR_W-1:0]      head_q, fill_q, idx_q;
  logic [PEND_W-1:0]     pend_q;
  logic [NROW_W-1:0]     orow_q;
  logic [COL_W-1:0]      ocol_q;
  logic [2:0]            k_q;
  logic                  skip_q;
  logic [VALUE_BITS-1:0] res_q;
  logic                  filled_q, fend_q;
  logic [SUM_W-1:0]      sum_q, quo_q;
  logic [3:0]            cnt_q, rem_q;
  logic [STEP_W-1:0]     step_q;

  logic [NCOL_W-1:0]     eff_n;
  logic [NROW_W-1:0]     eff_r;
  logic [MINN_W-1:0]     eff_minn;
  logic [CALC_W-1:0]     n_w, p_w, f_w, h_w, i_w, c_w, idx_w, dmag, addr_w;
  logic [PEND_W-1:0]     pend_base;
  logic [PTR_W-1:0]      fill_base;
  logic [NROW_W:0]       r_w, nr_w;
  nb_ofs_t               ofs;
  logic                  row_ok, col_ok, dist_ok, d_pos;
  logic                  ram_we, ram_re;
  logic [PTR_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  rd_msk;
  logic [4:0]            rem_sh;
  logic                  rem_ge;

  // Effective configuration
  always_comb begin
    if (ncols_q == '0) eff_n = NCOL_W'(1);
    else if (32'(ncols_q) > MAX_COLS) eff_n = NCOL_W'(MAX_COLS);
    else eff_n = ncols_q;
    eff_r    = (nrows_q == '0) ? NROW_W'(1) : nrows_q;
    eff_minn = (minn_q == '0) ? MINN_W'(1) : minn_q;
  end

  assign n_w = CALC_W'(eff_n);
  assign p_w = CALC_W'(pend_q);
  assign f_w = CALC_W'(fill_q);
  assign h_w = CALC_W'(head_q);
  assign i_w = CALC_W'(idx_q);
  assign c_w = CALC_W'(ocol_q);

  // Accept side: frame start discards pending pixels
  assign pend_base = frame_start_i ? '0 : pend_q;
  assign fill_base = frame_start_i ? '0 : fill_q;
  assign stat_o.emit_req = (cmd_i == CMD_DRAIN) ? (pend_q != '0)
                         : (CALC_W'(pend_base) + 1'b1 > n_w + 1'b1);

  // Oldest pending pixel
  assign idx_w = (h_w >= p_w) ? h_w - p_w : h_w + CALC_W'(RING) - p_w;

  // Neighbor clipping, age check and address
  assign ofs  = nb_offset(k_q);
  assign r_w  = {1'b0, orow_q};
  assign nr_w = {1'b0, eff_r};
  always_comb begin
    if (ofs.r_neg) row_ok = (orow_q != '0) && (r_w - 1'b1 < nr_w);
    else if (ofs.r_pos) row_ok = (r_w + 1'b1 < nr_w);
    else row_ok = (r_w < nr_w);

    if (ofs.c_neg) col_ok = (ocol_q != '0) && (c_w - 1'b1 < n_w);
    else if (ofs.c_pos) col_ok = (c_w + 1'b1 < n_w);
    else col_ok = (c_w < n_w);

    // Signed ring distance as sign and magnitude
    if (ofs.r_pos) begin
      d_pos = 1'b1;
      dmag  = ofs.c_neg ? n_w - 1'b1 : (ofs.c_pos ? n_w + 1'b1 : n_w);
      if (ofs.c_neg && n_w == CALC_W'(1)) d_pos = 1'b0;
    end else if (ofs.r_neg) begin
      d_pos = 1'b0;
      dmag  = ofs.c_neg ? n_w + 1'b1 : (ofs.c_pos ? n_w - 1'b1 : n_w);
      if (ofs.c_pos && n_w == CALC_W'(1)) d_pos = 1'b0;
    end else begin
      d_pos = ofs.c_pos;
      dmag  = CALC_W'(1);
    end

    if (d_pos) dist_ok = (dmag < p_w);
    else dist_ok = (p_w + dmag <= f_w);

    if (d_pos) begin
      addr_w = i_w + dmag;
      if (addr_w >= CALC_W'(RING)) addr_w = addr_w - CALC_W'(RING);
    end else begin
      addr_w = (i_w >= dmag) ? i_w - dmag : i_w + CALC_W'(RING) - dmag;
    end
  end

  // Ring storage: mask bit over value
  assign ram_we    = cmd.accept && (cmd_i == CMD_PIXEL);
  assign ram_re    = cmd.ctr_rd || cmd.nb_rd;
  assign ram_raddr = cmd.ctr_rd ? idx_w[PTR_W-1:0] : addr_w[PTR_W-1:0];

  mhf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i ({in_domain_i, pixel_value_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_val = ram_rdata[VALUE_BITS-1:0];
  assign rd_msk = ram_rdata[VALUE_BITS];

  // Status toward the sequencer
  assign stat_o.hole     = rd_msk && (rd_val == '0);
  assign stat_o.nb_last  = (k_q == LAST_NEIGHBOR);
  assign stat_o.fill_ok  = (cnt_q >= eff_minn) && (cnt_q != '0);
  assign stat_o.div_last = (step_q == STEP_W'(SUM_W - 1));

  // Restoring divide step by the neighbor count
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, cnt_q});

  // Control state: configuration, ring pointers, positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncols_q <= NUM_COLS_RST;
      nrows_q <= NUM_ROWS_RST;
      minn_q  <= MIN_NEIGHBORS_RST;
      head_q  <= '0;
      fill_q  <= '0;
      pend_q  <= '0;
      orow_q  <= '0;
      ocol_q  <= '0;
      k_q     <= '0;
      step_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NUM_COLS:      ncols_q <= cfg_data_i[NCOL_W-1:0];
          CFG_NUM_ROWS:      nrows_q <= cfg_data_i[NROW_W-1:0];
          CFG_MIN_NEIGHBORS: minn_q  <= cfg_data_i[MINN_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        head_q <= (head_q == PTR_W'(RING - 1)) ? '0 : head_q + 1'b1;
        pend_q <= pend_base + 1'b1;
        fill_q <= (fill_base == PTR_W'(RING)) ? fill_base : fill_base + 1'b1;
        if (frame_start_i) begin
          orow_q <= '0;
          ocol_q <= '0;
        end
      end
      if (cmd.ctr_latch) k_q <= '0;
      if (cmd.nb_acc) k_q <= k_q + 1'b1;
      if (cmd.div_init) step_q <= '0;
      if (cmd.div_step) step_q <= step_q + 1'b1;
      // Advance the output position after the handoff
      if (cmd.out_done) begin
        pend_q <= pend_q - 1'b1;
        if (c_w + 1'b1 >= n_w) begin
          ocol_q <= '0;
          orow_q <= orow_q + 1'b1;
        end else begin
          ocol_q <= ocol_q + 1'b1;
        end
      end
    end
  end

  // Payload: window sum, divider and result
  always_ff @(posedge clk_i) begin
    if (cmd.ctr_rd) idx_q <= idx_w[PTR_W-1:0];
    if (cmd.ctr_latch) begin
      res_q    <= rd_val;
      filled_q <= 1'b0;
      fend_q   <= (orow_q == eff_r - 1'b1) && (c_w == n_w - 1'b1);
      sum_q    <= '0;
      cnt_q    <= '0;
    end
    if (cmd.nb_rd) skip_q <= !(row_ok && col_ok && dist_ok);
    if (cmd.nb_acc && !skip_q && rd_msk && (rd_val != '0)) begin
      cnt_q <= cnt_q + 1'b1;
      sum_q <= sum_q + SUM_W'(rd_val);
    end
    if (cmd.div_init) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end
    if (cmd.div_step) begin
      rem_q <= rem_ge ? 4'(rem_sh - {1'b0, cnt_q}) : rem_sh[3:0];
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
    end
    if (cmd.mean_load) begin
      res_q    <= quo_q[VALUE_BITS-1:0];
      filled_q <= 1'b1;
    end
  end

  assign out_value_o  = res_q;
  assign was_filled_o = filled_q;
  assign frame_end_o  = fend_q;

endmodule
